// ----- hdl/gear_status_frame_gateway_core_assert.svh -----
// assertion macros for the gear status frame gateway
// clk and rst_n must be visible where the macros are used
`ifndef GEAR_STATUS_FRAME_GATEWAY_CORE_ASSERT_SVH
`define GEAR_STATUS_FRAME_GATEWAY_CORE_ASSERT_SVH

// same-cycle implication, inactive during reset
`define GSFG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsfg assertion failed");

// next-cycle implication, inactive during reset
`define GSFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsfg assertion failed");

`endif

// ----- hdl/gsfg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsfg_pkg
// types and constants shared by the gear status frame gateway modules
// ---------------------------------------------------------------------------
package gsfg_pkg;

  // item kinds on the input stream
  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  // kinds on the result stream
  typedef enum logic {
    KIND_FORWARD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_STATUS_ID    = 2'd0,
    REG_PERIOD_TICKS = 2'd1,
    REG_ACTIVE_GEAR  = 2'd2
  } reg_idx_t;

  localparam int unsigned ID_W     = 11;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NBYTES   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned TDATA_W  = 80;
  localparam int unsigned PAD_W    = TDATA_W - ID_W - NBYTES * BYTE_W;

  // selector codes in byte 1 of a status id frame
  localparam logic [7:0] CODE_DRIVE   = 8'h15;
  localparam logic [7:0] CODE_NEUTRAL = 8'h16;
  localparam logic [7:0] CODE_REVERSE = 8'h17;
  localparam logic [7:0] CODE_PARK    = 8'h18;

  // drive logic values
  localparam logic [7:0] LOGIC_NONE    = 8'h00;
  localparam logic [7:0] LOGIC_FORWARD = 8'h01;
  localparam logic [7:0] LOGIC_REVERSE = 8'h02;

  localparam int unsigned DRIVE_BIT = 5;

  // reset values
  localparam logic [ID_W-1:0]     RST_STATUS_ID    = 11'h43F;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_TICKS = 16'd20;
  localparam logic [7:0]          RST_ACTIVE_GEAR  = 8'h00;
  localparam logic [7:0]          RST_GEAR         = 8'h06;

  typedef logic [NBYTES-1:0][BYTE_W-1:0] payload_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] frame_id;
    payload_t        data;
  } item_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] id;
    payload_t        data;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]     status_id;
    logic [PERIOD_W-1:0] period_ticks;
    logic [7:0]          active_gear;
  } cfg_t;

endpackage

// ----- hdl/gsfg_engine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsfg_engine
// gear state, tick counter and status frame builder; one item per step
// ---------------------------------------------------------------------------
module gsfg_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  gsfg_pkg::item_t  item,
  input  gsfg_pkg::cfg_t   cfg,
  output logic             emit,
  output gsfg_pkg::result_t result
);

  logic [7:0]                    gear_r, gear_nxt;
  logic [7:0]                    drive_logic_r, drive_logic_nxt;
  logic                          drive_flag_r, drive_flag_nxt;
  logic [3:0]                    alive_r, alive_nxt;
  logic [gsfg_pkg::PERIOD_W-1:0] tick_r, tick_nxt;
  logic [gsfg_pkg::PERIOD_W:0]   tick_inc;
  logic                          is_status;
  logic                          period_hit;
  logic [7:0]                    status_b0;
  logic [7:0]                    status_b3;

  // item decode
  assign is_status  = (item.cmd == gsfg_pkg::CMD_FRAME) &&
                      (item.frame_id == cfg.status_id);
  assign tick_inc   = {1'b0, tick_r} + {{gsfg_pkg::PERIOD_W{1'b0}}, 1'b1};
  assign period_hit = tick_inc >= {1'b0, cfg.period_ticks};

  // status frame bytes
  always_comb begin
    status_b0 = cfg.active_gear;
    status_b0[gsfg_pkg::DRIVE_BIT] = drive_flag_r;
    status_b3 = {~(alive_r ^ gear_r[3:0]), alive_r};
  end

  // result selection
  always_comb begin
    result = '0;
    emit   = 1'b0;
    if (item.cmd == gsfg_pkg::CMD_FRAME) begin
      emit          = !is_status;
      result.kind   = gsfg_pkg::KIND_FORWARD;
      result.id     = item.frame_id;
      result.data   = item.data;
    end else begin
      emit          = period_hit;
      result.kind   = gsfg_pkg::KIND_STATUS;
      result.id     = cfg.status_id;
      result.data[0] = status_b0;
      result.data[1] = gear_r;
      result.data[2] = drive_logic_r;
      result.data[3] = status_b3;
    end
  end

  // state update
  always_comb begin
    gear_nxt        = gear_r;
    drive_logic_nxt = drive_logic_r;
    drive_flag_nxt  = drive_flag_r;
    alive_nxt       = alive_r;
    tick_nxt        = tick_r;
    if (step) begin
      if (item.cmd == gsfg_pkg::CMD_TICK) begin
        if (period_hit) begin
          tick_nxt  = '0;
          alive_nxt = alive_r + 4'd1;
        end else begin
          tick_nxt  = tick_inc[gsfg_pkg::PERIOD_W-1:0];
        end
      end else if (is_status) begin
        gear_nxt = item.data[0];
        case (item.data[1])
          gsfg_pkg::CODE_DRIVE: begin
            drive_flag_nxt  = 1'b1;
            drive_logic_nxt = gsfg_pkg::LOGIC_FORWARD;
          end
          gsfg_pkg::CODE_NEUTRAL: begin
            drive_flag_nxt  = 1'b0;
            drive_logic_nxt = gsfg_pkg::LOGIC_FORWARD;
          end
          gsfg_pkg::CODE_REVERSE: begin
            drive_flag_nxt  = 1'b0;
            drive_logic_nxt = gsfg_pkg::LOGIC_REVERSE;
          end
          gsfg_pkg::CODE_PARK: begin
            drive_flag_nxt  = 1'b0;
            drive_logic_nxt = gsfg_pkg::LOGIC_NONE;
            gear_nxt        = 8'h00;
          end
          default: begin
            drive_flag_nxt  = drive_flag_r;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r        <= gsfg_pkg::RST_GEAR;
      drive_logic_r <= gsfg_pkg::LOGIC_NONE;
      drive_flag_r  <= 1'b0;
      alive_r       <= '0;
      tick_r        <= '0;
    end else begin
      gear_r        <= gear_nxt;
      drive_logic_r <= drive_logic_nxt;
      drive_flag_r  <= drive_flag_nxt;
      alive_r       <= alive_nxt;
      tick_r        <= tick_nxt;
    end
  end

endmodule

// ----- hdl/gear_status_frame_gateway_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gear_status_frame_gateway_core
// gear status gateway: swallows status id frames, forwards the rest and
// emits a periodic status frame on time ticks
// ---------------------------------------------------------------------------
//  channel   direction  content
//  in_       slave      tuser: cmd; tdata: frame_id, bytes 0..7
//  out_      master     tuser: kind; tdata: id, bytes 0..7
//  cfg_      write      status_id, period_ticks, active_gear
//
//  one request per cycle unless a stalled result fills the input register; a result is offered from the result register
//  an input register feeds the engine, a result register drives out_
//  reset is synchronous, loads the reset values into state and config and clears both valid flags
//  items that give no result still pass through the input register
//  a stalled result holds the pipeline only when the input register is full
// ---------------------------------------------------------------------------
module gear_status_frame_gateway_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gsfg_pkg::TDATA_W-1:0]  in_tdata,   // frame_id, in_byte0..in_byte7, pad
  input  logic                          in_tuser,   // cmd
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gsfg_pkg::TDATA_W-1:0]  out_tdata,  // out_id, out_byte0..out_byte7, pad
  output logic                          out_tuser,  // out_kind
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [gsfg_pkg::CFG_W-1:0]    cfg_wdata
);

  gsfg_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  gsfg_pkg::item_t   s1_item_r, s1_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  gsfg_pkg::result_t out_res_r, out_res_nxt;
  gsfg_pkg::item_t   in_item;
  gsfg_pkg::result_t eng_result;
  logic              eng_emit;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        gsfg_pkg::REG_STATUS_ID:
          cfg_nxt.status_id = cfg_wdata[gsfg_pkg::ID_W-1:0];
        gsfg_pkg::REG_PERIOD_TICKS:
          cfg_nxt.period_ticks = cfg_wdata[gsfg_pkg::PERIOD_W-1:0];
        gsfg_pkg::REG_ACTIVE_GEAR:
          cfg_nxt.active_gear = cfg_wdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // unpack input request
  always_comb begin
    in_item.cmd      = gsfg_pkg::cmd_t'(in_tuser);
    in_item.frame_id = in_tdata[gsfg_pkg::ID_W-1:0];
    in_item.data     = in_tdata[gsfg_pkg::ID_W +: gsfg_pkg::NBYTES*gsfg_pkg::BYTE_W];
  end

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = in_item;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  gsfg_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .emit   (eng_emit),
    .result (eng_result)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_free) begin
      out_valid_nxt = s1_adv && eng_emit;
      if (s1_adv && eng_emit) begin
        out_res_nxt = eng_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_id    <= gsfg_pkg::RST_STATUS_ID;
      cfg_r.period_ticks <= gsfg_pkg::RST_PERIOD_TICKS;
      cfg_r.active_gear  <= gsfg_pkg::RST_ACTIVE_GEAR;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r              <= cfg_nxt;
      s1_valid_r         <= s1_valid_nxt;
      out_valid_r        <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  // pack result request
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {{gsfg_pkg::PAD_W{1'b0}}, out_res_r.data, out_res_r.id};

endmodule

// ----- hdl/gsfg_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsfg_checker
// port-level checks on the gear status frame gateway
// ---------------------------------------------------------------------------
`include "gear_status_frame_gateway_core_assert.svh"

module gsfg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [gsfg_pkg::TDATA_W-1:0]  out_tdata,
  input logic                          out_tuser
);

  // a stalled result keeps its request
  `GSFG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // input stalls only behind a stalled result
  `GSFG_ASSERT_IMPL(a_stall_cause, !in_tready, out_tvalid && !out_tready)

  // status frames carry zero trailing bytes
  `GSFG_ASSERT_IMPL(a_status_tail, out_tvalid && out_tuser, out_tdata[74:43] == 32'h0)

  // checksum nibble agrees with counter and gear byte
  `GSFG_ASSERT_IMPL(a_status_chk, out_tvalid && out_tuser, out_tdata[42:39] == ~(out_tdata[38:35] ^ out_tdata[22:19]))

endmodule

bind gear_status_frame_gateway_core gsfg_checker u_gsfg_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the gear status frame gateway: frames and ticks go
// in on the input stream, a built-in gateway predictor forecasts forwarded
// and status frames, and every outgoing frame is compared field by field
// ---------------------------------------------------------------------------
module tb_top;
  import gsfg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_PRINTED = 40;

  typedef logic [NBYTES-1:0][BYTE_W-1:0] bytes_t;

  // one outgoing frame as the bench sees it
  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] id;
    bytes_t          b;
  } frame_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata;   // frame_id, in_byte0..in_byte7, pad
  logic                 in_tuser;   // cmd
  logic                 out_tvalid;
  logic                 out_tready;
  logic [TDATA_W-1:0]   out_tdata;  // out_id, out_byte0..out_byte7, pad
  logic                 out_tuser;  // out_kind
  logic                 cfg_we;
  logic [1:0]           cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  // predictor copy of the registers
  logic [ID_W-1:0]      c_status_id;
  logic [PERIOD_W-1:0]  c_period;
  logic [7:0]           c_active_gear;
  // predictor copy of the state
  logic [7:0]           m_gear;
  logic [7:0]           m_logic;
  logic                 m_flag;
  logic [3:0]           m_alive;
  logic [PERIOD_W-1:0]  m_ticks;

  frame_t awaited_frames[$];
  int     err_count;
  int     cycle_count;
  bit     tx_quiet;
  bit     rx_quiet;
  bit     hold_req;

  gear_status_frame_gateway_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gear_status_frame_gateway_core test failed");
      $finish;
    end
  end

  // id in the low bits, then bytes 0..7, zero pad on top
  function automatic logic [TDATA_W-1:0] pack_frame(logic [ID_W-1:0] id, bytes_t b);
    logic [TDATA_W-1:0] t;
    t = '0;
    t[ID_W-1:0] = id;
    for (int i = 0; i < NBYTES; i++) t[ID_W + BYTE_W*i +: BYTE_W] = b[i];
    return t;
  endfunction

  function automatic bytes_t rand_bytes();
    bytes_t b;
    for (int i = 0; i < NBYTES; i++) b[i] = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // gateway predictor: updates state and queues the frame the item causes
  function automatic void forecast_frame(cmd_t cmd, logic [ID_W-1:0] id, bytes_t b);
    frame_t f;
    logic [PERIOD_W:0] next_count;
    f = '0;
    if (cmd == CMD_FRAME) begin
      if (id == c_status_id) begin
        // status id frame is swallowed
        m_gear = b[0];
        case (b[1])
          CODE_DRIVE: begin
            m_flag = 1'b1;
            m_logic = LOGIC_FORWARD;
          end
          CODE_NEUTRAL: begin
            m_flag = 1'b0;
            m_logic = LOGIC_FORWARD;
          end
          CODE_REVERSE: begin
            m_flag = 1'b0;
            m_logic = LOGIC_REVERSE;
          end
          CODE_PARK: begin
            m_flag = 1'b0;
            m_logic = LOGIC_NONE;
            m_gear = 8'h00;
          end
          default: ;
        endcase
      end else begin
        f.kind = KIND_FORWARD;
        f.id = id;
        f.b = b;
        awaited_frames.push_back(f);
      end
    end else begin
      next_count = {1'b0, m_ticks} + 1'b1;
      if (next_count < {1'b0, c_period}) begin
        m_ticks = next_count[PERIOD_W-1:0];
      end else begin
        m_ticks = '0;
        f.kind = KIND_STATUS;
        f.id = c_status_id;
        f.b[0] = c_active_gear;
        f.b[0][DRIVE_BIT] = m_flag;
        f.b[1] = m_gear;
        f.b[2] = m_logic;
        f.b[3] = {~(m_alive ^ m_gear[3:0]), m_alive};
        awaited_frames.push_back(f);
        m_alive = m_alive + 4'd1;
      end
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (err_count < MAX_PRINTED)
      $display("mismatch on %s at %0t: got %0h expected %0h", field, $realtime, got, want);
    err_count++;
  endtask

  // one request on the input stream, predicted once accepted
  task automatic send_item(cmd_t cmd, logic [ID_W-1:0] id, bytes_t b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= pack_frame(id, b);
    do @(posedge clk); while (!in_tready);
    forecast_frame(cmd, id, b);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_item(CMD_TICK, 11'($urandom_range(0, 2047)), rand_bytes());
  endtask

  task automatic send_selector(logic [7:0] gear, logic [7:0] code);
    bytes_t b;
    b = rand_bytes();
    b[0] = gear;
    b[1] = code;
    send_item(CMD_FRAME, c_status_id, b);
  endtask

  // stop offering, wait for every awaited frame and let the pipe empty
  task automatic drain_to_idle();
    in_tvalid <= 1'b0;
    while (awaited_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STATUS_ID:    c_status_id = val[ID_W-1:0];
      REG_PERIOD_TICKS: c_period = val;
      REG_ACTIVE_GEAR:  c_active_gear = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) check_frame();
  end

  task automatic check_frame();
    frame_t want;
    bytes_t got_b;
    for (int i = 0; i < NBYTES; i++) got_b[i] = out_tdata[ID_W + BYTE_W*i +: BYTE_W];
    if (awaited_frames.size() == 0) begin
      report_mismatch("unexpected frame id", 32'(out_tdata[ID_W-1:0]), 32'd0);
    end else begin
      want = awaited_frames.pop_front();
      if (out_tuser !== want.kind)
        report_mismatch("out_kind", 32'(out_tuser), 32'(want.kind));
      if (out_tdata[ID_W-1:0] !== want.id)
        report_mismatch("out_id", 32'(out_tdata[ID_W-1:0]), 32'(want.id));
      for (int i = 0; i < NBYTES; i++)
        if (got_b[i] !== want.b[i])
          report_mismatch($sformatf("out_byte%0d", i), 32'(got_b[i]), 32'(want.b[i]));
    end
  endtask

  // result side: random stalls, plus one long hold when asked
  initial begin : rx_side
    int n;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      n = rx_quiet ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // reset values: first status frame after twenty ticks
  task automatic test_reset_defaults();
    send_ticks(int'(RST_PERIOD_TICKS));
    drain_to_idle();
  endtask

  // forwarded frames at the field extremes
  task automatic test_forwarding();
    send_item(CMD_FRAME, '0, '0);
    send_item(CMD_FRAME, '1, '1);
    send_item(CMD_FRAME, RST_STATUS_ID ^ 11'h001, rand_bytes());
    drain_to_idle();
  endtask

  // every selector code, each followed by a status frame
  task automatic test_selector_codes();
    write_reg(REG_PERIOD_TICKS, 16'd1);
    write_reg(REG_ACTIVE_GEAR, 16'h00FF);
    send_selector(8'h03, CODE_DRIVE);
    send_ticks(1);
    send_selector(8'hFF, CODE_NEUTRAL);
    send_ticks(1);
    send_selector(8'h00, CODE_REVERSE);
    send_ticks(1);
    send_selector(8'h0A, CODE_PARK);
    send_ticks(1);
    // unknown code only touches the gear byte
    send_selector(8'h5C, 8'h14);
    send_ticks(1);
    drain_to_idle();
  endtask

  // id and period extremes, period lowered below the running count
  task automatic test_config_extremes();
    write_reg(REG_STATUS_ID, 16'd0);
    write_reg(REG_PERIOD_TICKS, 16'd0);
    write_reg(REG_ACTIVE_GEAR, 16'h0000);
    send_selector(8'h41, CODE_DRIVE);
    send_item(CMD_FRAME, RST_STATUS_ID, rand_bytes());
    send_ticks(2);
    drain_to_idle();
    write_reg(REG_STATUS_ID, 16'h07FF);
    write_reg(REG_PERIOD_TICKS, 16'hFFFF);
    send_selector(8'h0E, CODE_REVERSE);
    send_item(CMD_FRAME, 11'd0, rand_bytes());
    send_ticks(3);
    drain_to_idle();
    write_reg(REG_PERIOD_TICKS, 16'd2);
    send_ticks(1);
    drain_to_idle();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(CMD_FRAME, c_status_id ^ 11'h100, rand_bytes());
    send_ticks(4);
    tx_quiet = 1'b0;
    drain_to_idle();
  endtask

  // phases of mixed traffic under changing settings
  task automatic test_random_traffic(int phases, int per_phase);
    int r;
    logic [7:0] code;
    logic [ID_W-1:0] id;
    for (int p = 0; p < phases; p++) begin
      r = $urandom_range(0, 9);
      write_reg(REG_STATUS_ID, (r == 0) ? 16'd0 : (r == 1) ? 16'h07FF :
                               16'($urandom_range(0, 2047)));
      r = $urandom_range(0, 9);
      write_reg(REG_PERIOD_TICKS, (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(10, 40)) :
                                  16'($urandom_range(1, 6)));
      r = $urandom_range(0, 9);
      write_reg(REG_ACTIVE_GEAR, (r == 0) ? 16'h0000 : (r == 1) ? 16'h00FF :
                                 16'($urandom_range(0, 255)));
      for (int i = 0; i < per_phase; i++) begin
        if (i % 25 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_ticks(1);
        end else if (r < 65) begin
          case ($urandom_range(0, 5))
            0: code = CODE_DRIVE;
            1: code = CODE_NEUTRAL;
            2: code = CODE_REVERSE;
            3: code = CODE_PARK;
            default: code = 8'($urandom_range(0, 255));
          endcase
          send_selector(8'($urandom_range(0, 255)), code);
        end else begin
          id = 11'($urandom_range(0, 2047));
          if ($urandom_range(0, 3) == 0) id = c_status_id ^ (11'd1 << $urandom_range(0, 10));
          send_item(CMD_FRAME, id, rand_bytes());
        end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      drain_to_idle();
    end
  endtask

  // sequence
  initial begin
    err_count = 0;
    cycle_count = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    hold_req = 1'b0;
    c_status_id = RST_STATUS_ID;
    c_period = RST_PERIOD_TICKS;
    c_active_gear = RST_ACTIVE_GEAR;
    m_gear = RST_GEAR;
    m_logic = LOGIC_NONE;
    m_flag = 1'b0;
    m_alive = '0;
    m_ticks = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= CMD_FRAME;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_STATUS_ID;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_forwarding();
    test_selector_codes();
    test_config_extremes();
    test_random_traffic(9, 100);
    test_backpressure();

    drain_to_idle();
    if (err_count == 0)
      $display("gear_status_frame_gateway_core test passed");
    else
      $display("gear_status_frame_gateway_core test failed");
    $finish;
  end

endmodule
